// ===== hw/rtl/dra_pkg.sv =====
// Shared types, constants and helpers for the damage rectangle accumulator.
`timescale 1ns / 1ps
`default_nettype none

package dra_pkg;

  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned COORD_W = $clog2(MAX_DIM);
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CIDX_W  = 2;

  // stream word widths, rounded up to whole bytes
  localparam int unsigned IN_BITS   = 4 * COORD_W + 1;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = 4 * COORD_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    CMD_MARK_CELL   = 2'd0,
    CMD_MARK_ROW    = 2'd1,
    CMD_MARK_SCREEN = 2'd2,
    CMD_FLUSH       = 2'd3
  } dra_cmd_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_SCREEN_ROWS = CIDX_W'(0),
    REG_SCREEN_COLS = CIDX_W'(1)
  } dra_reg_e;

  typedef struct packed {
    logic   dirty;
    coord_t top;
    coord_t left;
    coord_t bottom;
    coord_t right;
  } dra_rect_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
    logic   visible;
  } dra_cursor_t;

  typedef struct packed {
    dra_cmd_e    cmd;
    coord_t      row;
    coord_t      col;
    dra_cursor_t cursor;
  } dra_item_t;

  // Last valid index for a screen size: size clamped to 1..MAX_DIM, minus one.
  function automatic coord_t last_index(logic [CFG_W-1:0] size);
    logic [CFG_W-1:0] s;
    s = size;
    if (s == '0) s = CFG_W'(1);
    if (s > CFG_W'(MAX_DIM)) s = CFG_W'(MAX_DIM);
    return COORD_W'(s - CFG_W'(1));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/damage_rectangle_accumulator_unit.sv =====
// Top level of the damage rectangle accumulator.
`timescale 1ns / 1ps
`default_nettype none

// Keeps one bounding box of damaged character cells. Each input word is a
// command (tuser): mark a cell, mark a row, mark the whole screen, or flush.
// A flush first folds in the old and new cursor cells if the cursor moved,
// then, if anything is dirty, sends the box out as one word and goes clean.
// Throughput is one word per clock while the output is not held back: a word
// is captured in the input register, its effect on the box is computed
// combinationally and lands in the state and output registers when the output
// slot is free, so a result word passes the input and output registers in turn.
// Screen size registers may only be written while the block is idle.
module damage_rectangle_accumulator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // row, col, cursor_row, cursor_col, cursor_visible
  input  logic [dra_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // top row, left column, bottom row, right column
  output logic [dra_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dra_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [dra_pkg::CFG_W-1:0]          cfg_data_i
);
  import dra_pkg::*;

  localparam coord_t ROWS_LAST_RST = COORD_W'(23);
  localparam coord_t COLS_LAST_RST = COORD_W'(79);

  logic        in_valid_q;
  dra_item_t   in_q, in_d;
  logic        adv;

  dra_rect_t   rect_q, rect_d;
  dra_cursor_t seen_q, seen_d;
  coord_t      rows_last_q, cols_last_q;

  logic        emit;
  dra_rect_t   result;
  logic        out_valid_q;
  dra_rect_t   out_q;

  // stage moves when the output slot is free or being drained
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_d                = in_q;
    in_d.cmd            = dra_cmd_e'(s_axis_tuser);
    in_d.row            = s_axis_tdata[COORD_W-1:0];
    in_d.col            = s_axis_tdata[2*COORD_W-1:COORD_W];
    in_d.cursor.row     = s_axis_tdata[3*COORD_W-1:2*COORD_W];
    in_d.cursor.col     = s_axis_tdata[4*COORD_W-1:3*COORD_W];
    in_d.cursor.visible = s_axis_tdata[4*COORD_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_q <= in_d;
  end

  dra_update u_update (
    .item_i      (in_q),
    .rect_i      (rect_q),
    .seen_i      (seen_q),
    .rows_last_i (rows_last_q),
    .cols_last_i (cols_last_q),
    .rect_o      (rect_d),
    .seen_o      (seen_d),
    .emit_o      (emit),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_q      <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q && emit;
      if (in_valid_q) begin
        rect_q <= rect_d;
        seen_q <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q && emit) out_q <= result;
  end

  // screen size is held as its clamped last index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q <= ROWS_LAST_RST;
      cols_last_q <= COLS_LAST_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SCREEN_ROWS: rows_last_q <= last_index(cfg_data_i);
        REG_SCREEN_COLS: cols_last_q <= last_index(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_q.right, out_q.bottom, out_q.left, out_q.top});

endmodule

`default_nettype wire

// ===== hw/rtl/dra_update.sv =====
// Next-state and result logic for one command word.
`timescale 1ns / 1ps
`default_nettype none

module dra_update (
  input  dra_pkg::dra_item_t   item_i,
  input  dra_pkg::dra_rect_t   rect_i,
  input  dra_pkg::dra_cursor_t seen_i,
  input  dra_pkg::coord_t      rows_last_i,
  input  dra_pkg::coord_t      cols_last_i,
  output dra_pkg::dra_rect_t   rect_o,
  output dra_pkg::dra_cursor_t seen_o,
  output logic                 emit_o,
  output dra_pkg::dra_rect_t   result_o
);
  import dra_pkg::*;

  // Load on a clean rectangle, otherwise widen each edge.
  function automatic dra_rect_t mark(dra_rect_t s, coord_t r0, coord_t c0,
                                     coord_t r1, coord_t c1);
    dra_rect_t n;
    n = s;
    if (!s.dirty) begin
      n.top    = r0;
      n.left   = c0;
      n.bottom = r1;
      n.right  = c1;
    end else begin
      if (r0 < s.top)    n.top    = r0;
      if (c0 < s.left)   n.left   = c0;
      if (r1 > s.bottom) n.bottom = r1;
      if (c1 > s.right)  n.right  = c1;
    end
    n.dirty = 1'b1;
    return n;
  endfunction

  dra_rect_t flush_rect;
  logic      cursor_moved;

  assign cursor_moved = (item_i.cursor != seen_i);

  always_comb begin
    flush_rect = rect_i;
    if (cursor_moved) begin
      flush_rect = mark(rect_i, seen_i.row, seen_i.col, seen_i.row, seen_i.col);
      flush_rect = mark(flush_rect, item_i.cursor.row, item_i.cursor.col,
                        item_i.cursor.row, item_i.cursor.col);
    end
  end

  always_comb begin
    rect_o   = rect_i;
    seen_o   = seen_i;
    emit_o   = 1'b0;
    result_o = flush_rect;
    unique case (item_i.cmd)
      CMD_MARK_CELL: begin
        rect_o = mark(rect_i, item_i.row, item_i.col, item_i.row, item_i.col);
      end
      CMD_MARK_ROW: begin
        rect_o = mark(rect_i, item_i.row, '0, item_i.row, cols_last_i);
      end
      CMD_MARK_SCREEN: begin
        rect_o.dirty  = 1'b1;
        rect_o.top    = '0;
        rect_o.left   = '0;
        rect_o.bottom = rows_last_i;
        rect_o.right  = cols_last_i;
      end
      CMD_FLUSH: begin
        if (cursor_moved) seen_o = item_i.cursor;
        emit_o       = flush_rect.dirty;
        rect_o       = flush_rect;
        rect_o.dirty = 1'b0;
      end
      default: begin
        rect_o = rect_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/damage_rectangle_accumulator_unit_test.sv =====
// Self-checking testbench for the damage rectangle accumulator unit.
`timescale 1ns / 1ps

module damage_rectangle_accumulator_unit_test;
  import dra_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // indexes with no register behind them
  localparam logic [CIDX_W-1:0] REG_SPARE_LO = CIDX_W'(2);
  localparam logic [CIDX_W-1:0] REG_SPARE_HI = CIDX_W'(3);

  typedef struct {
    coord_t top;
    coord_t left;
    coord_t bottom;
    coord_t right;
  } rect_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
  logic [1:0]              s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CIDX_W-1:0]       cfg_index_i   = '0;
  logic [CFG_W-1:0]        cfg_data_i    = '0;

  damage_rectangle_accumulator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block's state
  logic [CFG_W-1:0] rows_reg    = CFG_W'(24);
  logic [CFG_W-1:0] cols_reg    = CFG_W'(80);
  rect_t            box         = '{'0, '0, '0, '0};
  logic             box_dirty   = 1'b0;
  dra_cursor_t      seen_cursor = '0;

  rect_t       rect_expect_q[$];
  dra_item_t   word_q[$];
  dra_item_t   cur_word;
  dra_cursor_t gen_cursor      = '0;
  int          words_queued    = 0;
  int          error_count     = 0;
  int          cycle_count     = 0;
  int          hold_asked      = 0;
  int          hold_served     = 0;
  int          stall_left      = 0;
  bit          sender_steady   = 1'b0;
  bit          receiver_steady = 1'b0;
  rect_t       want_rect;
  rect_t       got_rect;

  function automatic coord_t last_cell(logic [CFG_W-1:0] size);
    if (size == '0) return '0;
    if (size >= CFG_W'(MAX_DIM)) return coord_t'(MAX_DIM - 1);
    return coord_t'(size - 1'b1);
  endfunction

  function automatic void widen_box(coord_t r0, coord_t c0, coord_t r1, coord_t c1);
    if (!box_dirty) begin
      box       = '{r0, c0, r1, c1};
      box_dirty = 1'b1;
    end else begin
      if (r0 < box.top)    box.top    = r0;
      if (c0 < box.left)   box.left   = c0;
      if (r1 > box.bottom) box.bottom = r1;
      if (c1 > box.right)  box.right  = c1;
    end
  endfunction

  function automatic void predict_word(dra_item_t w);
    case (w.cmd)
      CMD_MARK_CELL: widen_box(w.row, w.col, w.row, w.col);
      CMD_MARK_ROW:  widen_box(w.row, '0, w.row, last_cell(cols_reg));
      CMD_MARK_SCREEN: begin
        box       = '{'0, '0, last_cell(rows_reg), last_cell(cols_reg)};
        box_dirty = 1'b1;
      end
      default: begin
        // cursor moved or changed visibility: old and new cells are damaged
        if (w.cursor != seen_cursor) begin
          widen_box(seen_cursor.row, seen_cursor.col, seen_cursor.row, seen_cursor.col);
          widen_box(w.cursor.row, w.cursor.col, w.cursor.row, w.cursor.col);
          seen_cursor = w.cursor;
        end
        if (box_dirty) begin
          rect_expect_q.push_back(box);
          box_dirty = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic void compare_field(string name, coord_t want, coord_t got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_word(cur_word);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_q.size() > 0 && (sender_steady || $urandom_range(99) >= 35)) begin
          cur_word = word_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_word.cmd;
          s_axis_tdata  <= IN_DATA_W'({cur_word.cursor.visible, cur_word.cursor.col,
                                       cur_word.cursor.row, cur_word.col, cur_word.row});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rect = '{m_axis_tdata[9:0], m_axis_tdata[19:10],
                   m_axis_tdata[29:20], m_axis_tdata[39:30]};
      if (rect_expect_q.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, got %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want_rect = rect_expect_q.pop_front();
        compare_field("top",    want_rect.top,    got_rect.top);
        compare_field("left",   want_rect.left,   got_rect.left);
        compare_field("bottom", want_rect.bottom, got_rect.bottom);
        compare_field("right",  want_rect.right,  got_rect.right);
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served   <= hold_asked;
      stall_left    <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= receiver_steady || $urandom_range(99) >= 35;
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL damage_rectangle_accumulator_unit");
    $finish;
  end

  function automatic dra_item_t make_word(dra_cmd_e c, coord_t r, coord_t cl,
                                          coord_t cr, coord_t cc, logic vis);
    dra_item_t w;
    w.cmd            = c;
    w.row            = r;
    w.col            = cl;
    w.cursor.row     = cr;
    w.cursor.col     = cc;
    w.cursor.visible = vis;
    return w;
  endfunction

  function automatic void queue_word(dra_item_t w);
    word_q.push_back(w);
    words_queued++;
    if (w.cmd == CMD_FLUSH) gen_cursor = w.cursor;
  endfunction

  function automatic coord_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return coord_t'(MAX_DIM - 1);
    if (pick < 50) return coord_t'($urandom_range(31));
    return coord_t'($urandom_range(MAX_DIM - 1));
  endfunction

  // mostly a run of marks closed by a flush, sometimes a lone stray word
  function automatic void queue_burst();
    int unsigned pick;
    int unsigned n;
    dra_cursor_t c;
    if ($urandom_range(99) < 10) begin
      queue_word(make_word(dra_cmd_e'($urandom_range(3)), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), 1'($urandom_range(1))));
      return;
    end
    n = $urandom_range(1, 6);
    repeat (n) begin
      pick = $urandom_range(99);
      queue_word(make_word(pick < 65 ? CMD_MARK_CELL : pick < 90 ? CMD_MARK_ROW : CMD_MARK_SCREEN,
                           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           1'($urandom_range(1))));
    end
    pick = $urandom_range(99);
    c    = gen_cursor;
    if (pick >= 60) begin
      c.row     = rand_coord();
      c.col     = rand_coord();
      c.visible = 1'($urandom_range(1));
    end else if (pick >= 45) begin
      c.visible = ~c.visible;
    end
    queue_word(make_word(CMD_FLUSH, rand_coord(), rand_coord(), c.row, c.col, c.visible));
  endfunction

  task automatic fill(int n);
    int goal;
    @(negedge clk_i);
    goal = words_queued + n;
    while (words_queued < goal) queue_burst();
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (word_q.size() != 0 || s_axis_tvalid || rect_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SCREEN_ROWS: rows_reg = val;
      REG_SCREEN_COLS: cols_reg = val;
      default: ;
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // clean flush with an unchanged cursor
    queue_word(make_word(CMD_FLUSH, '0, '0, '0, '0, 1'b0));
    // cursor fields ignored by a cell mark, row and col ignored by a flush
    queue_word(make_word(CMD_MARK_CELL, 10'd5, 10'd7, '1, '1, 1'b1));
    queue_word(make_word(CMD_FLUSH, '1, '1, '0, '0, 1'b0));
    queue_word(make_word(CMD_MARK_CELL, '1, '1, '0, '0, 1'b0));
    queue_word(make_word(CMD_MARK_CELL, '0, '0, '0, '0, 1'b0));
    queue_word(make_word(CMD_MARK_CELL, 10'd512, 10'd3, '0, '0, 1'b0));
    queue_word(make_word(CMD_FLUSH, '0, '0, '0, '0, 1'b0));
    queue_word(make_word(CMD_MARK_ROW, 10'd10, '1, '1, '1, 1'b1));
    queue_word(make_word(CMD_MARK_ROW, 10'd3, '0, '0, '0, 1'b0));
    queue_word(make_word(CMD_FLUSH, '0, '0, '0, '0, 1'b0));
    // a whole-screen mark replaces what was there
    queue_word(make_word(CMD_MARK_CELL, 10'd500, 10'd900, '0, '0, 1'b0));
    queue_word(make_word(CMD_MARK_SCREEN, '1, '1, '1, '1, 1'b1));
    queue_word(make_word(CMD_FLUSH, '0, '0, '0, '0, 1'b0));
    queue_word(make_word(CMD_MARK_SCREEN, '0, '0, '0, '0, 1'b0));
    queue_word(make_word(CMD_MARK_CELL, 10'd100, 10'd200, '0, '0, 1'b0));
    queue_word(make_word(CMD_FLUSH, '0, '0, '0, '0, 1'b0));
    // cursor move on a clean block, then visibility alone, then no change, then a move
    queue_word(make_word(CMD_FLUSH, '0, '0, '1, '1, 1'b1));
    queue_word(make_word(CMD_FLUSH, '0, '0, '1, '1, 1'b0));
    queue_word(make_word(CMD_FLUSH, '0, '0, '1, '1, 1'b0));
    queue_word(make_word(CMD_FLUSH, '0, '0, 10'd7, 10'd9, 1'b0));
    wait_idle();

    fill(150);
    wait_idle();

    write_reg(REG_SCREEN_ROWS, CFG_W'(MAX_DIM));
    write_reg(REG_SCREEN_COLS, CFG_W'(MAX_DIM));
    fill(150);
    sender_steady   = 1'b1;
    receiver_steady = 1'b1;
    wait_idle();
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;

    // zero sizes act as one; spare indexes must leave the sizes alone
    write_reg(REG_SCREEN_ROWS, '0);
    write_reg(REG_SCREEN_COLS, '0);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, CFG_W'($urandom_range(2047)));
    fill(150);
    hold_asked++;
    wait_idle();

    // oversize values clamp to the largest screen
    write_reg(REG_SCREEN_ROWS, '1);
    write_reg(REG_SCREEN_COLS, CFG_W'(MAX_DIM + 1));
    fill(75);
    wait_idle();
    fill(75);
    wait_idle();

    write_reg(REG_SCREEN_ROWS, CFG_W'(1));
    write_reg(REG_SCREEN_COLS, CFG_W'(2));
    fill(150);
    wait_idle();

    write_reg(REG_SCREEN_ROWS, CFG_W'($urandom_range(1, MAX_DIM)));
    write_reg(REG_SCREEN_COLS, CFG_W'($urandom_range(1, MAX_DIM)));
    fill(150);
    wait_idle();

    if (error_count == 0) begin
      $display("PASS damage_rectangle_accumulator_unit");
    end else begin
      $display("FAIL damage_rectangle_accumulator_unit");
    end
    $finish;
  end

endmodule
